[rtl/positional_list_engine_unit_defines.svh]
// Assertion macros for the positional list engine.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH

// Checked only while out of reset
`define PLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included
`define PLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/ple_pkg.sv]
// Shared sizes, opcodes and the per-cell control struct of the list engine.
// No dependencies.
package ple_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;

  // count runs 0..CAPACITY, cell index 0..CAPACITY-1
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);
  localparam int IDX_BITS   = $clog2(CAPACITY);
  // common width for comparing the 5-bit position against the count
  localparam int CMP_BITS   = (COUNT_BITS > 5) ? COUNT_BITS : 5;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_ERASE  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // What one cell does in the current cycle
  typedef struct packed {
    logic load;       // take the new value
    logic from_left;  // take the entry of the cell in front (insert shift)
    logic from_right; // take the entry of the cell behind (erase shift)
  } cell_ctrl_t;

endpackage

[rtl/ple_cell.sv]
// One storage cell of the list chain: holds a single entry.
// Depends on ple_pkg for the value width and the control struct.
module ple_cell import ple_pkg::*; (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [VALUE_BITS-1:0] new_value_i,
  input  logic [VALUE_BITS-1:0] left_value_i,
  input  logic [VALUE_BITS-1:0] right_value_i,
  output logic [VALUE_BITS-1:0] value_o
);

  logic [VALUE_BITS-1:0] value_q, value_d;

  // next entry: load, shift in from a neighbour, or hold
  always_comb begin
    priority if (ctrl_i.load) begin
      value_d = new_value_i;
    end else if (ctrl_i.from_left) begin
      value_d = left_value_i;
    end else if (ctrl_i.from_right) begin
      value_d = right_value_i;
    end else begin
      value_d = value_q;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

[rtl/positional_list_engine_unit.sv]
// Top level of the positional list engine: request decode, cell chain,
// count register and result register. Depends on ple_pkg, ple_cell and
// positional_list_engine_unit_defines.svh.

// Ordered list of up to CAPACITY signed entries held in a row of cells.
// Each request (append, insert, erase, read) is handled whole: on an
// insert or erase the cells from the position on move their entries one
// place to or from a neighbour in parallel, so a new request is taken every
// cycle while the result register is empty or being drained. Results are
// registered, out in the cycle after the request. Refused requests leave
// the list untouched and set rejected; read_data is 0 but for a read in range.
`include "positional_list_engine_unit_defines.svh"

module positional_list_engine_unit import ple_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [4:0]         position_i,
  input  logic signed [31:0] item_value_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] read_data_o,
  output logic [4:0]         entry_count_o,
  output logic               rejected_o
);

  logic                  accept;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [CMP_BITS-1:0]   pos_ext, cnt_ext;
  logic                  full, pos_le_cnt, pos_lt_cnt;
  logic                  ok, rej;
  logic [VALUE_BITS-1:0] new_value;
  logic [VALUE_BITS-1:0] cell_value [CAPACITY];
  cell_ctrl_t            cell_ctrl  [CAPACITY];
  logic signed [31:0]    rd_value;

  logic                  out_valid_q;
  logic signed [31:0]    read_data_q;
  logic [4:0]            entry_count_q;
  logic                  rejected_q;

  // handshake: result register parts the two sides
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // range checks
  assign pos_ext    = CMP_BITS'(position_i);
  assign cnt_ext    = CMP_BITS'(count_q);
  assign full       = (count_q == COUNT_BITS'(CAPACITY));
  assign pos_le_cnt = (pos_ext <= cnt_ext);
  assign pos_lt_cnt = (pos_ext < cnt_ext);
  assign new_value  = VALUE_BITS'(item_value_i);

  always_comb begin
    unique case (op_i)
      OP_APPEND: ok = !full;
      OP_INSERT: ok = pos_le_cnt && !full;
      OP_ERASE:  ok = pos_lt_cnt;
      OP_READ:   ok = pos_lt_cnt;
      default:   ok = 1'b0;
    endcase
  end
  assign rej = !ok;

  // count update
  always_comb begin
    count_d = count_q;
    if (accept && ok) begin
      unique case (op_i)
        OP_APPEND, OP_INSERT: count_d = count_q + COUNT_BITS'(1);
        OP_ERASE:             count_d = count_q - COUNT_BITS'(1);
        default:              count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // per-cell control and the chain itself
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CMP_BITS-1:0] Idx = CMP_BITS'(i);
    logic                  go;
    logic [VALUE_BITS-1:0] left_v, right_v;

    assign go = accept && ok;

    always_comb begin
      cell_ctrl[i] = '0;
      if (go) begin
        unique case (op_i)
          OP_APPEND: cell_ctrl[i].load = (Idx == cnt_ext);
          OP_INSERT: begin
            cell_ctrl[i].load      = (Idx == pos_ext);
            cell_ctrl[i].from_left = (Idx > pos_ext);
          end
          // entries past the end may shift too; they are never seen
          OP_ERASE:  cell_ctrl[i].from_right = (Idx >= pos_ext);
          default:   cell_ctrl[i] = '0;
        endcase
      end
    end

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_left
      assign left_v = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_right
      assign right_v = cell_value[i+1];
    end

    ple_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (cell_ctrl[i]),
      .new_value_i   (new_value),
      .left_value_i  (left_v),
      .right_value_i (right_v),
      .value_o       (cell_value[i])
    );
  end

  // read port: one selected cell, sign-extended
  always_comb begin
    rd_value = '0;
    if (op_i == OP_READ && ok) begin
      rd_value = 32'($signed(cell_value[pos_ext[IDX_BITS-1:0]]));
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_data_q   <= rd_value;
      entry_count_q <= 5'(count_d);
      rejected_q    <= rej;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = read_data_q;
  assign entry_count_o = entry_count_q;
  assign rejected_o    = rejected_q;

  // checks
  `PLE_ASSERT_ALWAYS(a_count_bound, !rst_ni || (count_q <= COUNT_BITS'(CAPACITY)), "count above capacity")
  `PLE_ASSERT(a_accept_result, accept |=> out_valid_o, "accepted request gave no result")
  `PLE_ASSERT(a_reject_hold, (accept && rej) |=> $stable(count_q), "refused request moved count")
  `PLE_ASSERT(a_reject_zero, (out_valid_o && rejected_o) |-> (read_data_o == 32'sd0), "refused request returned data")

endmodule

[dv/positional_list_engine_unit_tb.sv]
// Self-checking testbench for positional_list_engine_unit: a queue-fed request
// driver, a result monitor and an in-order list predictor.
// Depends on ple_pkg and the RTL of the list engine.
`timescale 1ns / 1ps

module positional_list_engine_unit_tb;
  import ple_pkg::*;

  typedef struct {
    logic [1:0]         op;
    logic [4:0]         pos;
    logic signed [31:0] val;
  } list_req_t;

  typedef struct {
    logic signed [31:0] read_data;
    logic [4:0]         entry_count;
    logic               rejected;
  } list_rsp_t;

  localparam int NUM_RANDOM = 1650;
  localparam int IDLE_LIMIT = 4000;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic [1:0]         op_i         = OP_APPEND;
  logic [4:0]         position_i   = '0;
  logic signed [31:0] item_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic signed [31:0] read_data_o;
  logic [4:0]         entry_count_o;
  logic               rejected_o;

  positional_list_engine_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_o  (read_data_o),
    .entry_count_o(entry_count_o),
    .rejected_o   (rejected_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  list_req_t          list_req_q[$];
  list_rsp_t          expected_results[$];
  int                 mismatches = 0;

  // Predicted list contents and length
  logic signed [31:0] list_mem[CAPACITY];
  int                 list_len = 0;

  // Length tracked while generating, to aim positions at the live range
  int                 gen_len = 0;

  // Apply one request to the predicted list and return the result it gives
  function automatic list_rsp_t apply_list_op(list_req_t req);
    list_rsp_t rsp;
    rsp.read_data   = '0;
    rsp.entry_count = '0;
    rsp.rejected    = 1'b0;
    case (req.op)
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          rsp.rejected = 1'b1;
        end else begin
          list_mem[list_len] = req.val;
          list_len++;
        end
      end
      OP_INSERT: begin
        if (int'(req.pos) > list_len || list_len >= CAPACITY) begin
          rsp.rejected = 1'b1;
        end else begin
          for (int i = list_len; i > int'(req.pos); i--) list_mem[i] = list_mem[i-1];
          list_mem[req.pos] = req.val;
          list_len++;
        end
      end
      OP_ERASE: begin
        if (int'(req.pos) >= list_len) begin
          rsp.rejected = 1'b1;
        end else begin
          for (int i = int'(req.pos); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      default: begin
        if (int'(req.pos) >= list_len) begin
          rsp.rejected = 1'b1;
        end else begin
          rsp.read_data = list_mem[req.pos];
        end
      end
    endcase
    rsp.entry_count = list_len[4:0];
    return rsp;
  endfunction

  // Queue one request and keep the generator's length in step
  task automatic queue_req(logic [1:0] op, logic [4:0] pos, logic signed [31:0] val);
    list_req_t req;
    req.op  = op;
    req.pos = pos;
    req.val = val;
    list_req_q.insert(list_req_q.size(), req);
    case (op)
      OP_APPEND: if (gen_len < CAPACITY) gen_len++;
      OP_INSERT: if (int'(pos) <= gen_len && gen_len < CAPACITY) gen_len++;
      OP_ERASE:  if (int'(pos) < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  // Idle length: mostly none or short, a few long, with idle-free bursts
  function automatic int pick_gap(inout int burst_left);
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 1) begin
      burst_left = $urandom_range(30, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // Request driver
  list_req_t cur_req;
  int        req_gap   = 0;
  int        req_burst = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        expected_results.insert(expected_results.size(), apply_list_op(cur_req));
      if (!in_valid_i || in_ready_o) begin
        if (req_gap > 0) begin
          req_gap--;
          in_valid_i <= 1'b0;
        end else if (list_req_q.size() > 0) begin
          cur_req      = list_req_q.pop_front();
          op_i         <= cur_req.op;
          position_i   <= cur_req.pos;
          item_value_i <= cur_req.val;
          in_valid_i   <= 1'b1;
          req_gap      = pick_gap(req_burst);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result-side back-pressure
  int rsp_stall = 0;
  int rsp_burst = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rsp_stall > 0) begin
      rsp_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      rsp_stall   = pick_gap(rsp_burst);
    end
  end

  task automatic report_field(string field, logic [31:0] expv, logic [31:0] actv);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, expv, actv);
  endtask

  // Result monitor
  always @(posedge clk_i) begin
    list_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with no request outstanding, read_data %h count %0d rej %b",
                 $time, read_data_o, entry_count_o, rejected_o);
      end else begin
        want = expected_results.pop_front();
        if (read_data_o !== want.read_data)
          report_field("read_data", want.read_data, read_data_o);
        if (entry_count_o !== want.entry_count)
          report_field("entry_count", 32'(want.entry_count), 32'(entry_count_o));
        if (rejected_o !== want.rejected)
          report_field("rejected", 32'(want.rejected), 32'(rejected_o));
      end
    end
  end

  // Watchdog on handshake progress
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int mode;
    int r;
    logic [1:0] op;
    logic [4:0] pos;

    // Directed: empty list, extremes, boundaries, full list
    queue_req(OP_READ,   5'd0,  32'sd1);          // read of empty list
    queue_req(OP_ERASE,  5'd0,  32'sd0);          // erase of empty list
    queue_req(OP_INSERT, 5'd1,  32'sd5);          // insert past the end
    queue_req(OP_APPEND, 5'd31, 32'sh7FFF_FFFF);
    queue_req(OP_APPEND, 5'd0,  32'sh8000_0000);
    queue_req(OP_INSERT, 5'd0,  -32'sd1);         // insert at the front
    queue_req(OP_INSERT, 5'd3,  32'sd0);          // insert at the end
    queue_req(OP_READ,   5'd0,  32'sd0);
    queue_req(OP_READ,   5'd3,  32'sd0);
    queue_req(OP_READ,   5'd4,  32'sd0);          // read at count
    queue_req(OP_READ,   5'd31, 32'sd0);          // read far out of range
    queue_req(OP_ERASE,  5'd1,  32'sd0);
    queue_req(OP_ERASE,  5'd3,  32'sd0);          // erase at count
    while (gen_len < CAPACITY) queue_req(OP_APPEND, 5'($urandom), $urandom);
    queue_req(OP_APPEND, 5'd0,  32'sd9);          // append to full list
    queue_req(OP_INSERT, 5'd0,  32'sd9);          // insert into full list
    queue_req(OP_READ,   5'd15, 32'sd0);
    queue_req(OP_READ,   5'd16, 32'sd0);
    queue_req(OP_ERASE,  5'd15, 32'sd0);          // erase the last entry
    queue_req(OP_ERASE,  5'd0,  32'sd0);          // erase the first entry

    // Random: phases that grow, shrink or hold the list, with some noise
    mode = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 60 == 0) mode = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        op  = 2'($urandom);
        pos = 5'($urandom);
      end else begin
        r = $urandom_range(0, 99);
        case (mode)
          0:       op = (r < 35) ? OP_APPEND : (r < 70) ? OP_INSERT : (r < 80) ? OP_ERASE : OP_READ;
          1:       op = (r < 10) ? OP_APPEND : (r < 25) ? OP_INSERT : (r < 75) ? OP_ERASE : OP_READ;
          default: op = (r < 25) ? OP_APPEND : (r < 50) ? OP_INSERT : (r < 75) ? OP_ERASE : OP_READ;
        endcase
        if ($urandom_range(0, 19) == 0) begin
          pos = 5'(gen_len + (op == OP_INSERT ? 1 : 0));   // first position refused
        end else if (op == OP_INSERT) begin
          pos = 5'($urandom_range(0, gen_len));
        end else begin
          pos = (gen_len > 0) ? 5'($urandom_range(0, gen_len - 1)) : 5'd0;
        end
      end
      queue_req(op, pos, pick_value());
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (list_req_q.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (expected_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine_unit.sv
dv/positional_list_engine_unit_tb.sv
